// File: rtl/deadline_timer_queue_macros.svh
// Assertion macros for the deadline timer queue.
// Included by the controller and datapath; no other dependencies.
`ifndef DEADLINE_TIMER_QUEUE_MACROS_SVH
`define DEADLINE_TIMER_QUEUE_MACROS_SVH

// same-cycle implication, disabled in reset
`define DTQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/dtq_pkg.sv
// Shared constants, codes and control structs of the deadline timer queue.
// No dependencies.
package dtq_pkg;

    localparam int DEPTH       = 16;
    localparam int MAX_RESULTS = 16;

    localparam int TIME_W   = 64;
    localparam int ID_W     = 16;
    localparam int DELAY_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = $clog2(DEPTH + 1);
    localparam int CNT_W    = $clog2(MAX_RESULTS + 1);

    localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [STATUS_W-1:0] ST_ADDED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FIRED = 2'd2;

    typedef struct packed {
        logic                load_add;
        logic                load_tick;
        logic                insert;
        logic                drop;
        logic                emit;
        logic                sel_head;
        logic                last;
        logic [STATUS_W-1:0] status;
    } t_dtq_cmd;

    typedef struct packed {
        logic full;
        logic head_due;
        logic next_due;
        logic out_free;
    } t_dtq_stat;

endpackage

// File: rtl/dtq_if.sv
// Request and response channel interfaces of the deadline timer queue.
// Depends on dtq_pkg.
interface dtq_req_if import dtq_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               kind;
    logic [ID_W-1:0]    task_id;
    logic [DELAY_W-1:0] delay;

    modport source (output valid, kind, task_id, delay, input ready);
    modport sink   (input valid, kind, task_id, delay, output ready);
endinterface

interface dtq_rsp_if import dtq_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     fired_id;
    logic                last;

    modport source (output valid, status, fired_id, last, input ready);
    modport sink   (input valid, status, fired_id, last, output ready);
endinterface

// File: rtl/dtq_ctrl.sv
// Controller of the deadline timer queue: one-hot sequencer for add and tick words.
// Depends on dtq_pkg and deadline_timer_queue_macros.svh.
`include "deadline_timer_queue_macros.svh"

module dtq_ctrl import dtq_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    input  logic      i_kind,
    input  t_dtq_stat i_stat,
    output logic      o_ready,
    output t_dtq_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_ADD  = 3'b010,
        S_TICK = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               w_acc;
    logic               w_last;

    assign o_ready = (r_state == S_IDLE);
    assign w_acc   = o_ready && i_valid;
    assign w_last  = !(i_stat.next_due && (r_cnt < CNT_LAST));

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                n_cnt = '0;
                if (w_acc) begin
                    if (i_kind == KIND_TICK) begin
                        o_cmd.load_tick = 1'b1;
                        n_state         = S_TICK;
                    end else begin
                        o_cmd.load_add = 1'b1;
                        n_state        = S_ADD;
                    end
                end
            end
            S_ADD: begin
                if (i_stat.out_free) begin
                    o_cmd.emit   = 1'b1;
                    o_cmd.last   = 1'b1;
                    o_cmd.insert = !i_stat.full;
                    o_cmd.status = i_stat.full ? ST_FULL : ST_ADDED;
                    n_state      = S_IDLE;
                end
            end
            S_TICK: begin
                if (!i_stat.head_due) begin
                    n_state = S_IDLE;
                end else if (i_stat.out_free) begin
                    o_cmd.emit     = 1'b1;
                    o_cmd.drop     = 1'b1;
                    o_cmd.sel_head = 1'b1;
                    o_cmd.last     = w_last;
                    o_cmd.status   = ST_FIRED;
                    n_cnt          = r_cnt + CNT_W'(1);
                    if (w_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    `DTQ_ASSERT_NOW(a_emit_slot, i_clk, i_rst_n, o_cmd.emit, i_stat.out_free, "emit into busy output register")
    `DTQ_ASSERT_NOW(a_drop_due, i_clk, i_rst_n, o_cmd.drop, i_stat.head_due && !o_cmd.insert, "drop of a head that is not due")
    `DTQ_ASSERT_NEXT(a_tick_scan, i_clk, i_rst_n, w_acc && i_kind == KIND_TICK, r_state == S_TICK && r_cnt == '0, "tick word did not start a scan")

endmodule

// File: rtl/dtq_datapath.sv
// Datapath of the deadline timer queue: time counter, sorted deadline list, output register.
// Depends on dtq_pkg and deadline_timer_queue_macros.svh.
`include "deadline_timer_queue_macros.svh"

module dtq_datapath import dtq_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dtq_cmd            i_cmd,
    input  logic [ID_W-1:0]     i_task_id,
    input  logic [DELAY_W-1:0]  i_delay,
    input  logic                i_out_ready,
    output t_dtq_stat           o_stat,
    output logic                o_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [ID_W-1:0]     o_fired_id,
    output logic                o_last
);

    logic [TIME_W-1:0]   r_now;
    logic [OCC_W-1:0]    r_occ;
    logic [TIME_W-1:0]   r_dl;
    logic [ID_W-1:0]     r_id;
    logic [TIME_W-1:0]   r_dls [DEPTH];
    logic [ID_W-1:0]     r_ids [DEPTH];
    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [ID_W-1:0]     r_o_id;
    logic                r_o_last;

    logic [DEPTH-1:0]    w_ge, w_lsb, w_after;
    logic [TIME_W-1:0]   w_dn_dl [DEPTH];
    logic [ID_W-1:0]     w_dn_id [DEPTH];
    logic [TIME_W-1:0]   w_up_dl [DEPTH];
    logic [ID_W-1:0]     w_up_id [DEPTH];

    // insertion point: first cell that is empty or later than the new deadline
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ge[i] = (OCC_W'(i) >= r_occ) || (r_dls[i] > r_dl);
        end
    end

    assign w_lsb   = w_ge & (~w_ge + DEPTH'(1));
    assign w_after = ~(w_lsb | (w_lsb - DEPTH'(1)));

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_dn_dl[g] = r_dl;
            assign w_dn_id[g] = r_id;
        end else begin : g_inner
            assign w_dn_dl[g] = r_dls[g-1];
            assign w_dn_id[g] = r_ids[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_up_dl[g] = r_dls[g];
            assign w_up_id[g] = r_ids[g];
        end else begin : g_body
            assign w_up_dl[g] = r_dls[g+1];
            assign w_up_id[g] = r_ids[g+1];
        end
    end

    assign o_stat.full     = (r_occ == OCC_FULL);
    assign o_stat.head_due = (r_occ != '0) && (r_dls[0] <= r_now);
    assign o_stat.next_due = (r_occ > OCC_W'(1)) && (r_dls[1] <= r_now);
    assign o_stat.out_free = !r_o_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_now <= '0;
            r_occ <= '0;
        end else begin
            if (i_cmd.load_tick) begin
                r_now <= r_now + TIME_W'(1);
            end
            if (i_cmd.insert) begin
                r_occ <= r_occ + OCC_W'(1);
            end else if (i_cmd.drop) begin
                r_occ <= r_occ - OCC_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_add) begin
            r_dl <= r_now + TIME_W'(i_delay);
            r_id <= i_task_id;
        end
    end

    // hold, shift up behind the new entry, or advance on drop
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            if (i_cmd.insert && w_lsb[i]) begin
                r_dls[i] <= r_dl;
                r_ids[i] <= r_id;
            end else if (i_cmd.insert && w_after[i]) begin
                r_dls[i] <= w_dn_dl[i];
                r_ids[i] <= w_dn_id[i];
            end else if (i_cmd.drop) begin
                r_dls[i] <= w_up_dl[i];
                r_ids[i] <= w_up_id[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_o_status <= i_cmd.status;
            r_o_last   <= i_cmd.last;
            r_o_id     <= i_cmd.sel_head ? r_ids[0] : r_id;
        end
    end

    assign o_valid    = r_o_valid;
    assign o_status   = r_o_status;
    assign o_fired_id = r_o_id;
    assign o_last     = r_o_last;

    `DTQ_ASSERT_NOW(a_insert_room, i_clk, i_rst_n, i_cmd.insert, r_occ != OCC_FULL && !i_cmd.drop, "insert into full list")
    `DTQ_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, i_cmd.insert, r_occ == $past(r_occ) + OCC_W'(1), "occupancy did not grow on insert")

endmodule

// File: rtl/deadline_timer_queue.sv
// Top level of the deadline timer queue: sorted millisecond timer list.
// Depends on dtq_pkg, dtq_if, dtq_ctrl and dtq_datapath.
//
//   channel  dir  word fields                    handshake
//   i_req    in   kind, task_id, delay           valid / ready
//   o_rsp    out  status, fired_id, last         valid / ready
//
// An add word: accept, then list insert and result load. A tick word: accept,
// then one result per fired task, or none when none is due; the single result
// register and the list head port set one fired task per cycle while o_rsp is not stalled.
// Reset (i_rst_n low, synchronous) clears time, occupancy and the output valid.
// A stalled o_rsp holds the sequencer; i_req is taken again once it returns to idle.
module deadline_timer_queue import dtq_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    dtq_req_if.sink  i_req,
    dtq_rsp_if.source o_rsp
);

    t_dtq_cmd  w_cmd;
    t_dtq_stat w_stat;

    dtq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .i_kind  (i_req.kind),
        .i_stat  (w_stat),
        .o_ready (i_req.ready),
        .o_cmd   (w_cmd)
    );

    dtq_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_task_id   (i_req.task_id),
        .i_delay     (i_req.delay),
        .i_out_ready (o_rsp.ready),
        .o_stat      (w_stat),
        .o_valid     (o_rsp.valid),
        .o_status    (o_rsp.status),
        .o_fired_id  (o_rsp.fired_id),
        .o_last      (o_rsp.last)
    );

endmodule
